// ===== design/pdc_pkg.sv =====
`timescale 1ns / 1ps

package pdc_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 31;
    localparam int unsigned ERR_W      = 17;
    localparam int unsigned MAG_W      = 16;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned LIMIT_W    = 31;
    localparam int unsigned OPND_W     = 19;
    localparam int unsigned PROD_W     = GAIN_W + OPND_W;
    localparam int unsigned SUM_W      = 48;
    localparam int unsigned DRIVE_W    = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_LOOP_MODE        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_INTEG       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_LIMIT      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_DEADBAND   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_SEPARATION = 3'd7;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                       loop_mode;
        logic signed [GAIN_W-1:0]   gain_prop;
        logic signed [GAIN_W-1:0]   gain_integ;
        logic signed [GAIN_W-1:0]   gain_deriv;
        logic [LIMIT_W-1:0]         output_limit;
        logic [LIMIT_W-1:0]         integ_limit;
        logic [MAG_W-1:0]           integ_deadband;
        logic [MAG_W-1:0]           integ_separation;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [MAG_W-1:0]        err_abs;
    } err_item_t;

    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] a,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] lim_pos;
        logic signed [SUM_W-1:0] lim_neg;
        logic signed [SUM_W-1:0] r;
        lim_pos = $signed({{(SUM_W-LIMIT_W){1'b0}}, lim});
        lim_neg = -lim_pos;
        r = a;
        if (a > lim_pos) begin
            r = lim_pos;
        end
        if (a < lim_neg) begin
            r = lim_neg;
        end
        return r[DRIVE_W-1:0];
    endfunction

endpackage

// ===== design/pid_position_delta_controller.sv =====
`timescale 1ns / 1ps
// Path: input transaction into the error register, then one pass through the gain
// multipliers, sums and clamps into the result register and the controller state.
// Throughput: one transaction per cycle while m_ready does not stall the output.
// Reset: aresetn synchronous active low; clears config registers, error history,
// integral, both held outputs and all valid flags.
module pid_position_delta_controller import pdc_pkg::*; #(
    parameter logic [15:0] ERR_ABORT_LIMIT = 16'd0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [15:0]    s_measured,
    input  logic signed [15:0]    s_target,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_drive,
    output logic                  m_error_aborted
);

    cfg_t      cfg;
    logic      e_valid;
    logic      e_ready;
    err_item_t e_item;

    pdc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdc_err_stage u_err (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_target   (s_target),
        .e_valid    (e_valid),
        .e_ready    (e_ready),
        .e_item     (e_item)
    );

    pdc_core #(
        .ERR_ABORT_LIMIT (ERR_ABORT_LIMIT)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .e_valid         (e_valid),
        .e_ready         (e_ready),
        .e_item          (e_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive         (m_drive),
        .m_error_aborted (m_error_aborted)
    );

endmodule

// ===== design/pdc_cfg_regs.sv =====
`timescale 1ns / 1ps

module pdc_cfg_regs import pdc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LOOP_MODE:        cfg_next.loop_mode        = cfg_wdata[0];
                REG_GAIN_PROP:        cfg_next.gain_prop        = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_INTEG:       cfg_next.gain_integ       = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_DERIV:       cfg_next.gain_deriv       = $signed(cfg_wdata[GAIN_W-1:0]);
                REG_OUTPUT_LIMIT:     cfg_next.output_limit     = cfg_wdata[LIMIT_W-1:0];
                REG_INTEG_LIMIT:      cfg_next.integ_limit      = cfg_wdata[LIMIT_W-1:0];
                REG_INTEG_DEADBAND:   cfg_next.integ_deadband   = cfg_wdata[MAG_W-1:0];
                REG_INTEG_SEPARATION: cfg_next.integ_separation = cfg_wdata[MAG_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/pdc_err_stage.sv =====
`timescale 1ns / 1ps

module pdc_err_stage import pdc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_measured,
    input  logic signed [15:0] s_target,
    output logic               e_valid,
    input  logic               e_ready,
    output err_item_t          e_item
);

    logic                    valid_reg;
    logic                    valid_next;
    err_item_t               item_reg;
    err_item_t               item_next;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] err_mag;

    assign s_ready = !valid_reg || e_ready;

    always_comb begin
        err     = ERR_W'(s_target) - ERR_W'(s_measured);
        err_mag = err[ERR_W-1] ? -err : err;
        item_next.err     = err;
        item_next.err_abs = err_mag[MAG_W-1:0];
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    assign e_valid = valid_reg;
    assign e_item  = item_reg;

endmodule

// ===== design/pdc_core.sv =====
`timescale 1ns / 1ps

module pdc_core import pdc_pkg::*; #(
    parameter logic [MAG_W-1:0] ERR_ABORT_LIMIT = 16'd0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  logic                      e_valid,
    output logic                      e_ready,
    input  err_item_t                 e_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive,
    output logic                      m_error_aborted
);

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      aborted_reg;
    logic                      aborted_next;

    logic signed [ERR_W-1:0]   err_prev_reg;
    logic signed [ERR_W-1:0]   err_prev_next;
    logic signed [ERR_W-1:0]   err_prev2_reg;
    logic signed [ERR_W-1:0]   err_prev2_next;
    logic signed [DRIVE_W-1:0] integ_acc_reg;
    logic signed [DRIVE_W-1:0] integ_acc_next;
    logic signed [DRIVE_W-1:0] pos_output_reg;
    logic signed [DRIVE_W-1:0] pos_output_next;
    logic signed [DRIVE_W-1:0] delta_output_reg;
    logic signed [DRIVE_W-1:0] delta_output_next;

    logic                      load;
    logic                      abort;
    logic                      integ_gate;
    logic signed [OPND_W-1:0]  e_x;
    logic signed [OPND_W-1:0]  d1;
    logic signed [OPND_W-1:0]  d2;
    logic signed [OPND_W-1:0]  op_p;
    logic signed [OPND_W-1:0]  op_d;
    logic signed [PROD_W-1:0]  prod_p;
    logic signed [PROD_W-1:0]  prod_i;
    logic signed [PROD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0]   acc_sum;
    logic signed [DRIVE_W-1:0] integ_new;
    logic signed [SUM_W-1:0]   pos_sum;
    logic signed [DRIVE_W-1:0] pos_new;
    logic signed [DRIVE_W-1:0] iterm;
    logic signed [SUM_W-1:0]   inc_sum;
    logic signed [DRIVE_W-1:0] delta_new;

    assign e_ready = !out_valid_reg || m_ready;
    assign load    = e_valid && e_ready;

    always_comb begin
        abort = (ERR_ABORT_LIMIT != '0) && (e_item.err_abs > ERR_ABORT_LIMIT);
        integ_gate = ((cfg.integ_deadband == '0) || (e_item.err_abs >= cfg.integ_deadband))
                  && ((cfg.integ_separation == '0)
                      || (e_item.err_abs <= cfg.integ_separation));

        e_x = OPND_W'(e_item.err);
        d1  = e_x - OPND_W'(err_prev_reg);
        d2  = e_x - (OPND_W'(err_prev_reg) <<< 1) + OPND_W'(err_prev2_reg);

        op_p = (cfg.loop_mode == MODE_INCREMENTAL) ? d1 : e_x;
        op_d = (cfg.loop_mode == MODE_INCREMENTAL) ? d2 : d1;

        prod_p = cfg.gain_prop * op_p;
        prod_i = cfg.gain_integ * e_x;
        prod_d = cfg.gain_deriv * op_d;

        // positional path
        acc_sum   = SUM_W'(integ_acc_reg) + (integ_gate ? SUM_W'(prod_i) : '0);
        integ_new = clamp_sym(acc_sum, cfg.integ_limit);
        pos_sum   = SUM_W'(prod_p) + SUM_W'(integ_new) + SUM_W'(prod_d);
        pos_new   = clamp_sym(pos_sum, cfg.output_limit);

        // incremental path
        iterm     = clamp_sym(SUM_W'(prod_i), cfg.integ_limit);
        inc_sum   = SUM_W'(delta_output_reg) + SUM_W'(prod_p) + SUM_W'(iterm)
                  + SUM_W'(prod_d);
        delta_new = clamp_sym(inc_sum, cfg.output_limit);
    end

    always_comb begin
        out_valid_next    = out_valid_reg;
        drive_next        = drive_reg;
        aborted_next      = aborted_reg;
        err_prev_next     = err_prev_reg;
        err_prev2_next    = err_prev2_reg;
        integ_acc_next    = integ_acc_reg;
        pos_output_next   = pos_output_reg;
        delta_output_next = delta_output_reg;

        if (e_ready) begin
            out_valid_next = e_valid;
        end

        if (load) begin
            if (abort) begin
                drive_next   = (cfg.loop_mode == MODE_INCREMENTAL) ? delta_output_reg
                                                                   : pos_output_reg;
                aborted_next = 1'b1;
            end else begin
                aborted_next   = 1'b0;
                err_prev2_next = err_prev_reg;
                err_prev_next  = e_item.err;
                if (cfg.loop_mode == MODE_INCREMENTAL) begin
                    delta_output_next = delta_new;
                    drive_next        = delta_new;
                end else begin
                    integ_acc_next  = integ_new;
                    pos_output_next = pos_new;
                    drive_next      = pos_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            err_prev_reg     <= '0;
            err_prev2_reg    <= '0;
            integ_acc_reg    <= '0;
            pos_output_reg   <= '0;
            delta_output_reg <= '0;
        end else begin
            out_valid_reg    <= out_valid_next;
            err_prev_reg     <= err_prev_next;
            err_prev2_reg    <= err_prev2_next;
            integ_acc_reg    <= integ_acc_next;
            pos_output_reg   <= pos_output_next;
            delta_output_reg <= delta_output_next;
        end
    end

    always_ff @(posedge aclk) begin
        drive_reg   <= drive_next;
        aborted_reg <= aborted_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_drive         = drive_reg;
    assign m_error_aborted = aborted_reg;

    a_abort_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        load && abort |=> $stable(err_prev_reg) && $stable(err_prev2_reg)
            && $stable(integ_acc_reg) && $stable(pos_output_reg)
            && $stable(delta_output_reg))
        else $error("abort transaction changed controller state");

    a_history_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !abort |=> (err_prev2_reg == $past(err_prev_reg))
            && (err_prev_reg == $past(e_item.err)))
        else $error("error history not shifted");

    a_no_abort_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (ERR_ABORT_LIMIT == '0) && m_valid |-> !m_error_aborted)
        else $error("abort flagged with abort limit disabled");

    a_drive_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error_aborted |->
            ($signed({drive_reg[DRIVE_W-1], drive_reg})
                <= $signed({2'b00, cfg.output_limit}))
            && ($signed({drive_reg[DRIVE_W-1], drive_reg})
                >= -$signed({2'b00, cfg.output_limit})))
        else $error("drive outside output limit");

endmodule
